/* sv/wtr_pkg.sv */
`default_nettype none

package wtr_pkg;

	// Field widths.
	localparam int unsigned WL_BITS      = 14;
	localparam int unsigned CHANNEL_BITS = 8;

	// Distance from a segment break in 1/16 nm; the widest span is 80 nm.
	localparam int unsigned DIST_BITS = 11;
	// Reciprocals round(2^28 / width) fit in 20 bits.
	localparam int unsigned RCP_BITS  = 20;
	// Q16 fractions that can reach exactly 1.0.
	localparam int unsigned FRAC_BITS = 17;
	localparam int unsigned PROD_BITS = DIST_BITS + RCP_BITS;

	// Queue between the classifier and the datapath.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Break points in 1/16 nm.
	localparam logic [WL_BITS-1:0] WL_380 = 14'd6080;
	localparam logic [WL_BITS-1:0] WL_420 = 14'd6720;
	localparam logic [WL_BITS-1:0] WL_440 = 14'd7040;
	localparam logic [WL_BITS-1:0] WL_490 = 14'd7840;
	localparam logic [WL_BITS-1:0] WL_510 = 14'd8160;
	localparam logic [WL_BITS-1:0] WL_580 = 14'd9280;
	localparam logic [WL_BITS-1:0] WL_645 = 14'd10320;
	localparam logic [WL_BITS-1:0] WL_700 = 14'd11200;
	localparam logic [WL_BITS-1:0] WL_780 = 14'd12480;

	// Reciprocals of the segment widths, round(2^28 / width in 1/16 nm).
	localparam logic [RCP_BITS-1:0] RCP_40NM = 20'd419430;
	localparam logic [RCP_BITS-1:0] RCP_80NM = 20'd209715;
	localparam logic [RCP_BITS-1:0] RCP_60NM = 20'd279620;
	localparam logic [RCP_BITS-1:0] RCP_50NM = 20'd335544;
	localparam logic [RCP_BITS-1:0] RCP_20NM = 20'd838861;
	localparam logic [RCP_BITS-1:0] RCP_70NM = 20'd239675;
	localparam logic [RCP_BITS-1:0] RCP_65NM = 20'd258111;

	// Brightness constants in Q16.
	localparam logic [FRAC_BITS-1:0] ONE_Q16 = 17'd65536;
	localparam logic [FRAC_BITS-1:0] S_BASE  = 17'd19661;
	localparam logic [15:0]          S_SPAN  = 16'd45875;

	// Color segment of a visible wavelength.
	typedef enum logic [2:0] {
		SEG_VIOLET,
		SEG_BLUE,
		SEG_CYAN,
		SEG_GREEN,
		SEG_YELLOW,
		SEG_RED
	} seg_t;

	// Classified request passed from the front end to the datapath.
	typedef struct packed {
		logic                 visible;
		logic                 ramp;
		logic                 ramp_hi;
		logic [DIST_BITS-1:0] bright_dist;
		seg_t                 seg;
		logic [DIST_BITS-1:0] seg_dist;
	} wtr_item_t;

endpackage

`default_nettype wire

/* sv/wtr_if.sv */
`default_nettype none

// Wavelength request channel.
interface wtr_wl_if;
	import wtr_pkg::*;

	logic               valid;
	logic               ready;
	logic [WL_BITS-1:0] wavelength;

	modport source(output valid, output wavelength, input ready);
	modport sink(input valid, input wavelength, output ready);
endinterface

// Color result channel.
interface wtr_rgb_if;
	import wtr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;
	logic                    visible;

	modport source(output valid, output red, output green, output blue, output visible,
		input ready);
	modport sink(input valid, input red, input green, input blue, input visible,
		output ready);
endinterface

`default_nettype wire

/* sv/wtr_front.sv */
`default_nettype none

module wtr_front (
	wtr_wl_if.sink             wl,
	input  logic               fifo_full,
	output logic               push,
	output wtr_pkg::wtr_item_t item
);
	import wtr_pkg::*;

	logic [WL_BITS-1:0] w;
	logic [WL_BITS-1:0] bright_diff;
	logic [WL_BITS-1:0] seg_diff;
	logic               ramp_lo;
	logic               ramp_hi;
	seg_t               seg;

	// A request is taken whenever the queue has room.
	assign wl.ready = !fifo_full;
	assign push     = wl.valid && !fifo_full;
	assign w        = wl.wavelength;

	// Brightness ramps at both ends of the band.
	assign ramp_lo     = w < WL_420;
	assign ramp_hi     = w > WL_700;
	assign bright_diff = ramp_lo ? (w - WL_380) : (WL_780 - w);

	// Find the color segment and the distance that its ramp runs over.
	always_comb begin
		if (w < WL_440) begin
			seg      = SEG_VIOLET;
			seg_diff = WL_440 - w;
		end else if (w < WL_490) begin
			seg      = SEG_BLUE;
			seg_diff = w - WL_440;
		end else if (w < WL_510) begin
			seg      = SEG_CYAN;
			seg_diff = WL_510 - w;
		end else if (w < WL_580) begin
			seg      = SEG_GREEN;
			seg_diff = w - WL_510;
		end else if (w < WL_645) begin
			seg      = SEG_YELLOW;
			seg_diff = WL_645 - w;
		end else begin
			seg      = SEG_RED;
			seg_diff = '0;
		end
	end

	// Pack the classified request.
	always_comb begin
		item.visible     = (w >= WL_380) && (w <= WL_780);
		item.ramp        = ramp_lo || ramp_hi;
		item.ramp_hi     = ramp_hi;
		item.bright_dist = bright_diff[DIST_BITS-1:0];
		item.seg         = seg;
		item.seg_dist    = seg_diff[DIST_BITS-1:0];
	end

endmodule

`default_nettype wire

/* sv/wtr_fifo.sv */
`default_nettype none

module wtr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wtr_pkg::wtr_item_t push_item,
	input  logic               pop,
	output logic               empty,
	output logic               full,
	output wtr_pkg::wtr_item_t head_item
);
	import wtr_pkg::*;

	wtr_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign empty     = count_q == '0;
	assign full      = count_q == FIFO_CW'(FIFO_DEPTH);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_item = mem_q[rd_ptr_q];

	// Storage needs no reset; only the pointers do.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/wtr_back.sv */
`default_nettype none

module wtr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fifo_empty,
	input  wtr_pkg::wtr_item_t head_item,
	output logic               pop,
	wtr_rgb_if.source          rgb
);
	import wtr_pkg::*;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_BRIGHT,
		SRC_LEVEL
	} ch_src_t;

	localparam int unsigned SPROD_BITS = 16 + FRAC_BITS;
	localparam int unsigned LPROD_BITS = 2 * FRAC_BITS;
	localparam int unsigned CPROD_BITS = FRAC_BITS + CHANNEL_BITS;
	localparam logic [CHANNEL_BITS-1:0] FULL = {CHANNEL_BITS{1'b1}};

	// Ramp position n / W in Q16, limited to 1.0.
	function automatic logic [FRAC_BITS-1:0] ramp_frac(
		input logic [DIST_BITS-1:0] n,
		input logic [RCP_BITS-1:0]  rcp
	);
		logic [PROD_BITS-1:0] prod;
		logic [PROD_BITS-1:0] rnd;
		prod = PROD_BITS'(n) * PROD_BITS'(rcp);
		rnd  = (prod + PROD_BITS'(2048)) >> 12;
		if (rnd > PROD_BITS'(ONE_Q16)) begin
			return ONE_Q16;
		end
		return rnd[FRAC_BITS-1:0];
	endfunction

	// Scale a Q16 level to the channel range, rounded to nearest.
	function automatic logic [CHANNEL_BITS-1:0] to_channel(input logic [FRAC_BITS-1:0] lvl);
		logic [CPROD_BITS-1:0] prod;
		prod = CPROD_BITS'(lvl) * CPROD_BITS'(FULL);
		prod = prod + CPROD_BITS'(32768);
		return prod[16 +: CHANNEL_BITS];
	endfunction

	logic                    advance;
	logic [RCP_BITS-1:0]     rcp_b;
	logic [RCP_BITS-1:0]     rcp_g;

	logic                    valid_s1;
	logic                    visible_s1;
	logic                    ramp_s1;
	seg_t                    seg_s1;
	logic [FRAC_BITS-1:0]    fb_s1;
	logic [FRAC_BITS-1:0]    fg_s1;

	logic [SPROD_BITS-1:0]   sprod;
	logic [SPROD_BITS-1:0]   sround;
	logic                    valid_s2;
	logic                    visible_s2;
	seg_t                    seg_s2;
	logic [FRAC_BITS-1:0]    s_s2;
	logic [FRAC_BITS-1:0]    fg_s2;

	logic [LPROD_BITS-1:0]   lprod;
	logic [LPROD_BITS-1:0]   lround;
	logic                    valid_s3;
	logic                    visible_s3;
	seg_t                    seg_s3;
	logic [FRAC_BITS-1:0]    s_s3;
	logic [FRAC_BITS-1:0]    level_s3;

	logic [CHANNEL_BITS-1:0] ch_bright;
	logic [CHANNEL_BITS-1:0] ch_level;
	ch_src_t                 src_r;
	ch_src_t                 src_g;
	ch_src_t                 src_b;
	logic                    valid_s4;
	logic                    visible_s4;
	logic [CHANNEL_BITS-1:0] red_s4;
	logic [CHANNEL_BITS-1:0] green_s4;
	logic [CHANNEL_BITS-1:0] blue_s4;

	// The whole pipeline moves when the output register is free or being drained.
	assign advance = !valid_s4 || rgb.ready;
	assign pop     = advance && !fifo_empty;

	// Reciprocal of the segment width for each ramp.
	assign rcp_b = head_item.ramp_hi ? RCP_80NM : RCP_40NM;
	always_comb begin
		case (head_item.seg)
			SEG_VIOLET: rcp_g = RCP_60NM;
			SEG_BLUE:   rcp_g = RCP_50NM;
			SEG_CYAN:   rcp_g = RCP_20NM;
			SEG_GREEN:  rcp_g = RCP_70NM;
			SEG_YELLOW: rcp_g = RCP_65NM;
			default:    rcp_g = '0;
		endcase
	end

	// Brightness factor from its ramp position.
	assign sprod  = SPROD_BITS'(S_SPAN) * SPROD_BITS'(fb_s1);
	assign sround = (sprod + SPROD_BITS'(32768)) >> 16;

	// Segment level scaled by brightness.
	assign lprod  = LPROD_BITS'(s_s2) * LPROD_BITS'(fg_s2);
	assign lround = (lprod + LPROD_BITS'(32768)) >> 16;

	// Channel values for the two possible sources.
	assign ch_bright = to_channel(s_s3);
	assign ch_level  = to_channel(level_s3);

	// Which value each channel shows in each segment.
	always_comb begin
		case (seg_s3)
			SEG_VIOLET: begin
				src_r = SRC_LEVEL;
				src_g = SRC_ZERO;
				src_b = SRC_BRIGHT;
			end
			SEG_BLUE: begin
				src_r = SRC_ZERO;
				src_g = SRC_LEVEL;
				src_b = SRC_BRIGHT;
			end
			SEG_CYAN: begin
				src_r = SRC_ZERO;
				src_g = SRC_BRIGHT;
				src_b = SRC_LEVEL;
			end
			SEG_GREEN: begin
				src_r = SRC_LEVEL;
				src_g = SRC_BRIGHT;
				src_b = SRC_ZERO;
			end
			SEG_YELLOW: begin
				src_r = SRC_BRIGHT;
				src_g = SRC_LEVEL;
				src_b = SRC_ZERO;
			end
			SEG_RED: begin
				src_r = SRC_BRIGHT;
				src_g = SRC_ZERO;
				src_b = SRC_ZERO;
			end
			default: begin
				src_r = SRC_ZERO;
				src_g = SRC_ZERO;
				src_b = SRC_ZERO;
			end
		endcase
		if (!visible_s3) begin
			src_r = SRC_ZERO;
			src_g = SRC_ZERO;
			src_b = SRC_ZERO;
		end
	end

	function automatic logic [CHANNEL_BITS-1:0] pick(
		input ch_src_t                 src,
		input logic [CHANNEL_BITS-1:0] bright,
		input logic [CHANNEL_BITS-1:0] lvl
	);
		case (src)
			SRC_BRIGHT: return bright;
			SRC_LEVEL:  return lvl;
			default:    return '0;
		endcase
	endfunction

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= !fifo_empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (advance) begin
			visible_s1 <= head_item.visible;
			ramp_s1    <= head_item.ramp;
			seg_s1     <= head_item.seg;
			fb_s1      <= ramp_frac(head_item.bright_dist, rcp_b);
			fg_s1      <= ramp_frac(head_item.seg_dist, rcp_g);

			visible_s2 <= visible_s1;
			seg_s2     <= seg_s1;
			fg_s2      <= fg_s1;
			s_s2       <= ramp_s1 ? (S_BASE + sround[FRAC_BITS-1:0]) : ONE_Q16;

			visible_s3 <= visible_s2;
			seg_s3     <= seg_s2;
			s_s3       <= s_s2;
			level_s3   <= lround[FRAC_BITS-1:0];

			visible_s4 <= visible_s3;
			red_s4     <= pick(src_r, ch_bright, ch_level);
			green_s4   <= pick(src_g, ch_bright, ch_level);
			blue_s4    <= pick(src_b, ch_bright, ch_level);
		end
	end

	assign rgb.valid   = valid_s4;
	assign rgb.visible = visible_s4;
	assign rgb.red     = red_s4;
	assign rgb.green   = green_s4;
	assign rgb.blue    = blue_s4;

endmodule

`default_nettype wire

/* sv/wavelength_to_rgb.sv */
// Wavelength to display color converter.
//
// Requests arrive on the wl channel: one 14-bit wavelength in 1/16 nm steps.
// Each request gives exactly one result on the rgb channel: red, green and
// blue intensities (full scale is all ones) and a visible flag that is set
// for 380 nm to 780 nm inclusive. Outside that band the result is black.
// Both channels use valid/ready; a request moves when both are high.
//
// Throughput is one request per cycle while rgb.ready stays high.
// A classifier accepts a request in the cycle it arrives, while there is
// room, and writes it to a four-entry queue; a four-stage datapath (ramp
// positions, brightness, level, channel scaling) drains the queue.
//
// When the receiver holds ready low, the datapath freezes with its result
// held in the output register, and the queue absorbs up to four further
// requests before wl.ready drops. Reset empties the queue and clears all
// stage valid flags; wl.ready is high right after reset.
`default_nettype none

module wavelength_to_rgb (
	input  logic      clk,
	input  logic      arst_n,
	wtr_wl_if.sink    wl,
	wtr_rgb_if.source rgb
);
	import wtr_pkg::*;

	wtr_item_t push_item;
	wtr_item_t head_item;
	logic      push;
	logic      pop;
	logic      fifo_empty;
	logic      fifo_full;

	// Classify incoming requests.
	wtr_front u_front (
		.wl        (wl),
		.fifo_full (fifo_full),
		.push      (push),
		.item      (push_item)
	);

	// Queue between front end and datapath.
	wtr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.empty     (fifo_empty),
		.full      (fifo_full),
		.head_item (head_item)
	);

	// Color datapath and output register.
	wtr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.head_item  (head_item),
		.pop        (pop),
		.rgb        (rgb)
	);

endmodule

`default_nettype wire

/* sv/wtr_checker.sv */
`default_nettype none

module wtr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [wtr_pkg::CHANNEL_BITS-1:0] red,
	input logic [wtr_pkg::CHANNEL_BITS-1:0] green,
	input logic [wtr_pkg::CHANNEL_BITS-1:0] blue,
	input logic                             visible
);
	import wtr_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue)
			&& $stable(visible))
		else $error("result changed while stalled");

	// Out-of-band wavelengths give black.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> red == '0 && green == '0 && blue == '0)
		else $error("invisible result is not black");

	// A visible wavelength always lights at least one channel at brightness.
	a_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && visible |-> red != '0 || green != '0 || blue != '0)
		else $error("visible result is black");

endmodule

bind wavelength_to_rgb wtr_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.red       (rgb.red),
	.green     (rgb.green),
	.blue      (rgb.blue),
	.visible   (rgb.visible)
);

`default_nettype wire

/* verif/tb_wavelength_to_rgb.sv */
`timescale 1ns / 1ps

module tb_wavelength_to_rgb;
	import wtr_pkg::*;

	localparam int unsigned RANDOM_REQS = 1300;
	localparam int unsigned STALL_AT    = 200;
	localparam int unsigned STALL_LEN   = 60;
	localparam int unsigned CALM_FROM   = 700;
	localparam int unsigned CALM_TO     = 1000;
	localparam int unsigned DRAIN_WAIT  = 12;

	// Break points in 1/16 nm.
	localparam int unsigned NM380 = 6080;
	localparam int unsigned NM420 = 6720;
	localparam int unsigned NM440 = 7040;
	localparam int unsigned NM490 = 7840;
	localparam int unsigned NM510 = 8160;
	localparam int unsigned NM580 = 9280;
	localparam int unsigned NM645 = 10320;
	localparam int unsigned NM700 = 11200;
	localparam int unsigned NM780 = 12480;

	// Reciprocals round(2^28 / span), span in 1/16 nm.
	localparam longint unsigned INV40 = 419430;
	localparam longint unsigned INV80 = 209715;
	localparam longint unsigned INV60 = 279620;
	localparam longint unsigned INV50 = 335544;
	localparam longint unsigned INV20 = 838861;
	localparam longint unsigned INV70 = 239675;
	localparam longint unsigned INV65 = 258111;

	localparam longint unsigned UNITY  = 65536;
	localparam longint unsigned DIM    = 19661;
	localparam longint unsigned BRIGHT = 45875;

	typedef struct {
		logic [WL_BITS-1:0]      wl;
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
		logic                    visible;
	} color_t;

	logic clk;
	logic arst_n;

	wtr_wl_if  wl_ch();
	wtr_rgb_if rgb_ch();

	wavelength_to_rgb dut (
		.clk    (clk),
		.arst_n (arst_n),
		.wl     (wl_ch),
		.rgb    (rgb_ch)
	);

	logic [WL_BITS-1:0] wl_pending[$];
	color_t             color_due[$];
	int unsigned        reqs_total;
	int unsigned        reqs_sent;
	int unsigned        colors_seen;
	int unsigned        visible_seen;
	int unsigned        errors;
	int unsigned        stall_left;
	bit                 stall_done;
	bit                 wl_took;

	// Position along a ramp of width 2^28/rcp, in Q16, limited to one.
	function automatic longint unsigned ramp_pos(longint unsigned n, longint unsigned rcp);
		longint unsigned f;
		f = (n * rcp + 2048) >> 12;
		return (f > UNITY) ? UNITY : f;
	endfunction

	function automatic longint unsigned dim_by(longint unsigned s, longint unsigned g);
		return (s * g + 32768) >> 16;
	endfunction

	function automatic logic [CHANNEL_BITS-1:0] to_level(longint unsigned lvl);
		longint unsigned full;
		full = (longint'(1) << CHANNEL_BITS) - 1;
		return CHANNEL_BITS'(((lvl * full + 32768) >> 16) & full);
	endfunction

	// Expected color for one wavelength.
	function automatic color_t predict_color(logic [WL_BITS-1:0] wl);
		color_t          c;
		longint unsigned w;
		longint unsigned s;
		longint unsigned r;
		longint unsigned g;
		longint unsigned b;
		c.wl = wl;
		w = wl;
		s = UNITY;
		r = 0;
		g = 0;
		b = 0;
		if (w < NM380 || w > NM780) begin
			c.red = '0;
			c.green = '0;
			c.blue = '0;
			c.visible = 1'b0;
			return c;
		end
		// Brightness falls off toward both ends of the band.
		if (w < NM420)
			s = DIM + ((BRIGHT * ramp_pos(w - NM380, INV40) + 32768) >> 16);
		else if (w > NM700)
			s = DIM + ((BRIGHT * ramp_pos(NM780 - w, INV80) + 32768) >> 16);
		// Hue segment.
		if (w < NM440) begin
			r = dim_by(s, ramp_pos(NM440 - w, INV60));
			b = s;
		end else if (w < NM490) begin
			g = dim_by(s, ramp_pos(w - NM440, INV50));
			b = s;
		end else if (w < NM510) begin
			g = s;
			b = dim_by(s, ramp_pos(NM510 - w, INV20));
		end else if (w < NM580) begin
			r = dim_by(s, ramp_pos(w - NM510, INV70));
			g = s;
		end else if (w < NM645) begin
			r = s;
			g = dim_by(s, ramp_pos(NM645 - w, INV65));
		end else begin
			r = s;
		end
		c.red = to_level(r);
		c.green = to_level(g);
		c.blue = to_level(b);
		c.visible = 1'b1;
		return c;
	endfunction

	task automatic report_mismatch(string what, logic [WL_BITS-1:0] wl, int got, int want);
		$display("[%0t] mismatch on %s for wavelength %0d: got %0d, expected %0d",
			$time, what, wl, got, want);
		errors++;
	endtask

	// Clock and reset.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		wl_ch.valid = 1'b0;
		wl_ch.wavelength = '0;
		rgb_ch.ready = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Request driver: offers the next pending wavelength unless it idles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!wl_ch.valid || wl_took) begin
				if (wl_pending.size() > 0 &&
					((reqs_sent >= CALM_FROM && reqs_sent < CALM_TO) ||
					$urandom_range(99) >= 6)) begin
					wl_ch.valid <= 1'b1;
					wl_ch.wavelength <= wl_pending.pop_front();
				end else begin
					wl_ch.valid <= 1'b0;
				end
			end
			wl_took = 1'b0;
		end
	end

	// Result receiver: random idling plus one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				rgb_ch.ready <= 1'b0;
			end else if (!stall_done && colors_seen >= STALL_AT) begin
				stall_done = 1'b1;
				stall_left = STALL_LEN - 1;
				rgb_ch.ready <= 1'b0;
			end else begin
				rgb_ch.ready <= (colors_seen >= CALM_FROM && colors_seen < CALM_TO) ||
					($urandom_range(99) >= 6);
			end
		end
	end

	// Monitor: checks results first, then records newly accepted requests.
	always @(posedge clk) begin
		color_t want;
		if (arst_n) begin
			if (rgb_ch.valid && rgb_ch.ready) begin
				colors_seen++;
				if (color_due.size() == 0) begin
					$display("[%0t] color result with no request outstanding", $time);
					errors++;
				end else begin
					want = color_due.pop_front();
					if (want.visible)
						visible_seen++;
					if (rgb_ch.red !== want.red)
						report_mismatch("red", want.wl, rgb_ch.red, want.red);
					if (rgb_ch.green !== want.green)
						report_mismatch("green", want.wl, rgb_ch.green, want.green);
					if (rgb_ch.blue !== want.blue)
						report_mismatch("blue", want.wl, rgb_ch.blue, want.blue);
					if (rgb_ch.visible !== want.visible)
						report_mismatch("visible", want.wl, rgb_ch.visible, want.visible);
				end
			end
			if (wl_ch.valid && wl_ch.ready) begin
				color_due.push_back(predict_color(wl_ch.wavelength));
				reqs_sent++;
				wl_took = 1'b1;
			end
		end
	end

	// Stimulus and end of test.
	initial begin
		int unsigned breaks[9];
		int unsigned pick;
		int unsigned k;
		breaks = '{NM380, NM420, NM440, NM490, NM510, NM580, NM645, NM700, NM780};
		reqs_sent = 0;
		colors_seen = 0;
		visible_seen = 0;
		errors = 0;
		stall_left = 0;
		stall_done = 1'b0;
		wl_took = 1'b0;

		// Field extremes and both sides of every break and band edge.
		wl_pending = '{14'd0, 14'd16383, 14'd6079, 14'd6080, 14'd6719, 14'd6720,
			14'd7039, 14'd7040, 14'd7839, 14'd7840, 14'd8159, 14'd8160,
			14'd9279, 14'd9280, 14'd10319, 14'd10320, 14'd11199, 14'd11200,
			14'd11201, 14'd12479, 14'd12480, 14'd12481};

		// Mostly visible wavelengths, some near breaks, some anywhere.
		for (k = 0; k < RANDOM_REQS; k++) begin
			pick = $urandom_range(99);
			if (pick < 75)
				wl_pending.push_back(WL_BITS'($urandom_range(NM780, NM380)));
			else if (pick < 90)
				wl_pending.push_back(WL_BITS'(breaks[$urandom_range(8)] +
					$urandom_range(8) - 4));
			else
				wl_pending.push_back(WL_BITS'($urandom_range(16383)));
		end
		reqs_total = wl_pending.size();

		while (reqs_sent < reqs_total || color_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d wavelengths (band edges, segment breaks, random), checked %0d colors,",
			reqs_sent, colors_seen);
		$display("%0d of them visible, with one %0d-cycle receiver hold-off.",
			visible_seen, STALL_LEN);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding", color_due.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
